[hw/rtl/ocmd_pkg.sv]
// Package for the one's-complement multiply/divide unit.
// Holds word constants, the pipeline stage record and the per-step arithmetic.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ocmd_pkg;

  localparam int unsigned WordW = 18;
  localparam int unsigned StepW = 5;

  localparam logic [WordW-1:0] WORD_ONES = 18'o777777;
  localparam logic [WordW-1:0] WORD_M2   = 18'o777776;
  localparam logic [WordW-1:0] WORD_ONE  = 18'o000001;

  // Operation codes.
  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_DIV = 1'b1;

  // Multiply runs seventeen steps, divide at most nineteen (step count 0 to 022).
  localparam int unsigned MulSteps = 17;
  localparam int unsigned NumIter  = 19;
  localparam logic [StepW-1:0] DIV_LAST = 5'o22;

  typedef struct packed {
    logic             cmd;
    logic [WordW-1:0] acc;
    logic [WordW-1:0] io;
    logic [WordW-1:0] op;
    logic             rs;   // Result sign.
    logic             os;   // Operand sign.
    logic             fin;  // Divide loop has ended.
    logic             ovf;  // Divide ended on overflow.
  } stage_t;

  // End-around-carry add.
  function automatic logic [WordW-1:0] ec_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  // Add with a minus-zero sum forced to plus zero.
  function automatic logic [WordW-1:0] add_step(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    if ((a ^ b) == WORD_ONES) begin
      return '0;
    end
    return ec_add(a, b);
  endfunction

  function automatic logic [WordW-1:0] inc_acc(input logic [WordW-1:0] a);
    if (a == WORD_M2) begin
      return '0;
    end else if (a == WORD_ONES) begin
      return WORD_ONE;
    end
    return a + WORD_ONE;
  endfunction

  // Sign fix-up ahead of the loop.
  function automatic stage_t prep(input logic cmd, input logic [WordW-1:0] acc_in,
                                  input logic [WordW-1:0] io_in,
                                  input logic [WordW-1:0] mem);
    stage_t r;
    r.cmd = cmd;
    r.os  = mem[WordW-1];
    r.fin = 1'b0;
    r.ovf = 1'b0;
    if (cmd == CMD_MUL) begin
      r.op  = mem[WordW-1] ? ~mem : mem;
      r.io  = acc_in[WordW-1] ? ~acc_in : acc_in;
      r.acc = '0;
      r.rs  = acc_in[WordW-1];
    end else begin
      r.op  = mem[WordW-1] ? mem : ~mem;
      r.acc = acc_in[WordW-1] ? ~acc_in : acc_in;
      r.io  = acc_in[WordW-1] ? ~io_in : io_in;
      r.rs  = acc_in[WordW-1];
    end
    return r;
  endfunction

  // One loop step; k is the step number of this pipeline stage.
  function automatic stage_t step(input stage_t s, input logic [StepW-1:0] k);
    stage_t           r;
    logic [WordW-1:0] a;
    logic [WordW-1:0] op1;
    logic [WordW-1:0] na;
    logic [WordW-1:0] nio;
    logic             done;
    r = s;
    if (s.cmd == CMD_MUL) begin
      if (k < StepW'(MulSteps)) begin
        a     = s.io[0] ? ec_add(s.acc, s.op) : s.acc;
        r.io  = {a[0], s.io[WordW-1:1]};
        r.acc = {1'b0, a[WordW-1:1]};
      end
    end else if (!s.fin) begin
      a    = add_step(s.acc, s.op);
      op1  = s.op[WordW-1] ? ~s.op : s.op;
      done = (k == DIV_LAST) || ((k == '0) && !a[WordW-1]);
      if (done) begin
        r.acc = a;
        r.op  = op1;
        r.fin = 1'b1;
        r.ovf = (k == '0);
      end else begin
        r.op = a[WordW-1] ? op1 : ~op1;
        na   = {a[WordW-2:0], s.io[WordW-1]};
        nio  = {s.io[WordW-2:0], ~a[WordW-1]};
        r.io  = nio;
        r.acc = a[WordW-1] ? inc_acc(na) : na;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ocmd_if.sv]
// Handshake interfaces for the multiply/divide unit: request and response.
// Depends on ocmd_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

interface ocmd_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [ocmd_pkg::WordW-1:0]   acc_in;
  logic [ocmd_pkg::WordW-1:0]   io_in;
  logic [ocmd_pkg::WordW-1:0]   mem_operand;
  modport source (output valid, cmd, acc_in, io_in, mem_operand, input ready);
  modport sink (input valid, cmd, acc_in, io_in, mem_operand, output ready);
endinterface

interface ocmd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ocmd_pkg::WordW-1:0]   acc_out;
  logic [ocmd_pkg::WordW-1:0]   io_out;
  logic                         skip;
  modport source (output valid, acc_out, io_out, skip, input ready);
  modport sink (input valid, acc_out, io_out, skip, output ready);
endinterface

`default_nettype wire

[hw/rtl/ones_complement_mul_div_top.sv]
// Eighteen-bit one's-complement multiply/divide unit, fully pipelined.
// Request channel (req): cmd (0 multiply, 1 divide), acc_in, io_in and
// mem_operand move in one transaction when valid and ready are both high.
// Response channel (rsp): acc_out, io_out and skip, one transaction per request,
// in request order.
// From request to response valid there is one stage for the sign
// fix-up, nineteen stages of one shift-and-add or non-restoring step each, and
// one stage for the final correction. Throughput is one transaction per cycle
// while the receiver does not stall; every step has its own pipeline stage and adder.
// A multiply uses the first seventeen step stages and passes through the rest;
// a divide that overflows passes through after its first step.
// Reset clears all stage valid bits; the pipeline then stands empty.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req.ready drops until the response is taken.
// Depends on ocmd_pkg and the interfaces in ocmd_if.
`timescale 1ns / 1ps
`default_nettype none

module ones_complement_mul_div_top (
  input  wire logic  clk,
  input  wire logic  rst,
  ocmd_req_if.sink   req,
  ocmd_rsp_if.source rsp
);

  localparam int unsigned N = ocmd_pkg::NumIter;

  ocmd_pkg::stage_t           stg [0:N];
  logic                       vld [0:N];
  logic                       out_vld;
  logic [ocmd_pkg::WordW-1:0] out_acc;
  logic [ocmd_pkg::WordW-1:0] out_io;
  logic                       out_skip;
  logic                       en;

  ocmd_pkg::stage_t           fs;
  logic [ocmd_pkg::WordW-1:0] fa;
  logic [ocmd_pkg::WordW-1:0] fio;
  logic [ocmd_pkg::WordW-1:0] facc;
  logic [ocmd_pkg::WordW-1:0] res_acc;
  logic [ocmd_pkg::WordW-1:0] res_io;
  logic                       res_skip;

  // The pipeline advances whenever the output register is free or being taken.
  assign en        = !out_vld || rsp.ready;
  assign req.ready = en;

  // Final correction on the last step stage.
  always_comb begin
    fs       = stg[N];
    res_skip = 1'b0;
    fa       = '0;
    fio      = '0;
    facc     = '0;
    if (fs.cmd == ocmd_pkg::CMD_MUL) begin
      if ((fs.rs != fs.os) && !((fs.acc == '0) && (fs.io == '0))) begin
        res_acc = ~fs.acc;
        res_io  = ~fs.io;
      end else begin
        res_acc = fs.acc;
        res_io  = fs.io;
      end
    end else begin
      res_skip = !fs.ovf;
      fa       = ocmd_pkg::add_step(fs.acc, fs.op);
      if (!fs.ovf) begin
        fa = {1'b0, fa[ocmd_pkg::WordW-1:1]};
      end
      fio = fs.io;
      if ((fs.ovf && fs.rs) || (!fs.ovf && (fs.io != '0) && (fs.rs != fs.os))) begin
        fio = ~fs.io;
      end
      facc = ((fa != '0) && fs.rs) ? ~fa : fa;
      if (!fs.ovf) begin
        res_acc = fio;
        res_io  = facc;
      end else begin
        res_acc = facc;
        res_io  = fio;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) begin
        vld[i] <= 1'b0;
      end
      out_vld <= 1'b0;
    end else if (en) begin
      vld[0] <= req.valid;
      for (int i = 0; i < N; i++) begin
        vld[i+1] <= vld[i];
      end
      out_vld <= vld[N];
    end
  end

  // Stage payloads: fix-up, one step per stage, then the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= ocmd_pkg::prep(req.cmd, req.acc_in, req.io_in, req.mem_operand);
      for (int i = 0; i < N; i++) begin
        stg[i+1] <= ocmd_pkg::step(stg[i], ocmd_pkg::StepW'(i));
      end
      out_acc  <= res_acc;
      out_io   <= res_io;
      out_skip <= res_skip;
    end
  end

  assign rsp.valid   = out_vld;
  assign rsp.acc_out = out_acc;
  assign rsp.io_out  = out_io;
  assign rsp.skip    = out_skip;

endmodule

`default_nettype wire
